@@ design/aimed_point_motion_stepper_macros.svh @@
// Assertion helpers for the aimed point motion stepper.
`ifndef AIMED_POINT_MOTION_STEPPER_MACROS_SVH
`define AIMED_POINT_MOTION_STEPPER_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define APMS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: label");

// Next-cycle implication, ignored while reset is high.
`define APMS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: label");

`endif

@@ design/apms_pkg.sv @@
package apms_pkg;

   localparam int COORD_BITS = 24;
   localparam int FRAC_BITS  = 8;
   localparam int SPEED_BITS = 16;
   localparam int SPEED_FRAC = 8;

   localparam int DIFF_BITS = COORD_BITS + 1;
   // the larger normalized magnitude lives in [2^(NORM_BITS-1), 2^NORM_BITS)
   localparam int NORM_BITS = 30;
   localparam int PROD_BITS = 2 * NORM_BITS;
   localparam int SQ_BITS   = PROD_BITS + 1;
   localparam int ROOT_BITS = NORM_BITS + 1;
   localparam int RAD_BITS  = 2 * ROOT_BITS;
   localparam int REM_BITS  = ROOT_BITS + 2;
   localparam int NUM_BITS  = NORM_BITS + SPEED_BITS + FRAC_BITS;
   localparam int DEN_BITS  = ROOT_BITS + SPEED_FRAC;
   localparam int QUOT_BITS = SPEED_BITS + FRAC_BITS - SPEED_FRAC + 1;
   localparam int WIDE_BITS = QUOT_BITS + COORD_BITS;
   localparam int STEP_MAX  = (ROOT_BITS > QUOT_BITS) ? ROOT_BITS : QUOT_BITS;
   localparam int STEP_BITS = $clog2(STEP_MAX);

   typedef logic signed [COORD_BITS-1:0] coord_type;

   localparam coord_type COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam coord_type COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

   localparam logic [SPEED_BITS-1:0] SPEED_RESET = SPEED_BITS'(256);

   localparam logic [1:0] REQ_MOVE  = 2'd0;
   localparam logic [1:0] REQ_PLACE = 2'd1;
   localparam logic [1:0] REQ_AIM   = 2'd2;

   typedef enum logic [14:0] {
      ST_IDLE = 15'b000000000000001,
      ST_EXEC = 15'b000000000000010,
      ST_NORM = 15'b000000000000100,
      ST_SQA  = 15'b000000000001000,
      ST_SQB  = 15'b000000000010000,
      ST_SUM  = 15'b000000000100000,
      ST_ROOT = 15'b000000001000000,
      ST_MULX = 15'b000000010000000,
      ST_LDX  = 15'b000000100000000,
      ST_DIVX = 15'b000001000000000,
      ST_MULY = 15'b000010000000000,
      ST_LDY  = 15'b000100000000000,
      ST_DIVY = 15'b001000000000000,
      ST_DONE = 15'b010000000000000,
      ST_WAIT = 15'b100000000000000
   } state_type;

   typedef struct packed {
      logic load_req;
      logic commit_simple;
      logic diff;
      logic norm_shift;
      logic sq_a;
      logic sq_b;
      logic root_init;
      logic root_step;
      logic mul_x;
      logic mul_y;
      logic keep_x;
      logic div_init;
      logic div_step;
      logic commit_aim;
   } dp_cmd_type;

   typedef struct packed {
      logic is_aim;
      logic zero_dist;
      logic norm_done;
      logic out_free;
   } dp_stat_type;

endpackage

@@ design/apms_ctrl.sv @@
module apms_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  apms_pkg::dp_stat_type stat,
   output apms_pkg::dp_cmd_type  cmd
);
   import apms_pkg::*;

   state_type              state_ff, state_in;
   logic [STEP_BITS-1:0]   step_ff, step_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (stat.is_aim) begin
               cmd.diff = 1'b1;
               state_in = ST_NORM;
            end else if (stat.out_free) begin
               cmd.commit_simple = 1'b1;
               state_in          = ST_IDLE;
            end
         end
         ST_NORM: begin
            if (stat.zero_dist) begin
               state_in = ST_DONE;
            end else if (stat.norm_done) begin
               state_in = ST_SQA;
            end else begin
               cmd.norm_shift = 1'b1;
            end
         end
         ST_SQA: begin
            cmd.sq_a = 1'b1;
            state_in = ST_SQB;
         end
         ST_SQB: begin
            cmd.sq_b = 1'b1;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            cmd.root_init = 1'b1;
            step_in       = '0;
            state_in      = ST_ROOT;
         end
         ST_ROOT: begin
            cmd.root_step = 1'b1;
            step_in       = step_ff + 1'b1;
            if (step_ff == STEP_BITS'(ROOT_BITS - 1)) begin
               state_in = ST_MULX;
            end
         end
         ST_MULX: begin
            cmd.mul_x = 1'b1;
            state_in  = ST_LDX;
         end
         ST_LDX: begin
            cmd.div_init = 1'b1;
            step_in      = '0;
            state_in     = ST_DIVX;
         end
         ST_DIVX: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (step_ff == STEP_BITS'(QUOT_BITS - 1)) begin
               state_in = ST_MULY;
            end
         end
         ST_MULY: begin
            cmd.mul_y  = 1'b1;
            cmd.keep_x = 1'b1;
            state_in   = ST_LDY;
         end
         ST_LDY: begin
            cmd.div_init = 1'b1;
            step_in      = '0;
            state_in     = ST_DIVY;
         end
         ST_DIVY: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (step_ff == STEP_BITS'(QUOT_BITS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            // hold until the output register can take the response
            if (stat.out_free) begin
               cmd.commit_aim = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

@@ design/apms_datapath.sv @@
module apms_datapath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  apms_pkg::dp_cmd_type                   cmd,
   output apms_pkg::dp_stat_type                  stat,
   input  logic [1:0]                             req_type,
   input  logic signed [apms_pkg::COORD_BITS-1:0] req_in_x,
   input  logic signed [apms_pkg::COORD_BITS-1:0] req_in_y,
   input  logic                                   csr_wr_en,
   input  logic [apms_pkg::SPEED_BITS-1:0]        csr_wr_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [apms_pkg::COORD_BITS-1:0] rsp_pos_x,
   output logic signed [apms_pkg::COORD_BITS-1:0] rsp_pos_y,
   output logic signed [apms_pkg::COORD_BITS-1:0] rsp_step_x,
   output logic signed [apms_pkg::COORD_BITS-1:0] rsp_step_y,
   output logic                                   rsp_degenerate,
   output logic                                   rsp_clipped
);
   import apms_pkg::*;

   // architectural state
   logic [SPEED_BITS-1:0] speed_ff;
   coord_type             point_x_ff, point_y_ff, disp_x_ff, disp_y_ff;
   logic                  zero_aim_ff;

   // captured request
   logic [1:0]            op_type_ff;
   coord_type             op_x_ff, op_y_ff;

   // aim datapath
   logic                  neg_x_ff, neg_y_ff;
   logic [NORM_BITS-1:0]  a_ff, b_ff;
   logic [PROD_BITS-1:0]  prod_ff;
   logic [SQ_BITS-1:0]    sq_ff;
   logic [RAD_BITS-1:0]   rad_ff;
   logic [REM_BITS-1:0]   rem_ff;
   logic [ROOT_BITS-1:0]  root_ff;
   logic [DEN_BITS-1:0]   drem_ff;
   logic [QUOT_BITS-1:0]  dlow_ff, quot_ff, quot_x_ff;

   // response register
   logic                  rsp_valid_ff;
   coord_type             out_pos_x_ff, out_pos_y_ff, out_step_x_ff, out_step_y_ff;
   logic                  out_degen_ff, out_clip_ff;

   // combinational
   logic signed [DIFF_BITS-1:0] dx, dy, sum_x, sum_y;
   logic [DIFF_BITS-1:0]        mag_x, mag_y;
   logic [NORM_BITS-1:0]        mul_lhs, mul_rhs;
   logic [PROD_BITS-1:0]        mul_out;
   logic [REM_BITS+1:0]         root_try, root_sub;
   logic                        root_bit;
   logic [NUM_BITS-1:0]         num;
   logic [DEN_BITS-1:0]         den;
   logic [DEN_BITS:0]           div_try;
   logic                        div_bit;
   coord_type                   mv_x, mv_y, nxt_pt_x, nxt_pt_y;
   logic                        clip_x, clip_y, nxt_clip;
   coord_type                   comp_x, comp_y;
   logic                        out_free;

   function automatic coord_type make_comp(logic [QUOT_BITS-1:0] q, logic neg);
      logic [WIDE_BITS-1:0] qw;
      logic [WIDE_BITS-1:0] lim;
      coord_type            m;
      qw  = WIDE_BITS'(q);
      lim = WIDE_BITS'(COORD_MAX);
      m   = (qw > lim) ? COORD_MAX : COORD_BITS'(qw);
      return neg ? -m : m;
   endfunction

   assign out_free = !rsp_valid_ff || rsp_ready;

   assign stat.is_aim    = (op_type_ff == REQ_AIM);
   assign stat.zero_dist = (a_ff == '0) && (b_ff == '0);
   assign stat.norm_done = a_ff[NORM_BITS-1] || b_ff[NORM_BITS-1];
   assign stat.out_free  = out_free;

   // distance to target
   always_comb begin
      dx    = {op_x_ff[COORD_BITS-1], op_x_ff} - {point_x_ff[COORD_BITS-1], point_x_ff};
      dy    = {op_y_ff[COORD_BITS-1], op_y_ff} - {point_y_ff[COORD_BITS-1], point_y_ff};
      mag_x = dx[DIFF_BITS-1] ? DIFF_BITS'(-dx) : DIFF_BITS'(dx);
      mag_y = dy[DIFF_BITS-1] ? DIFF_BITS'(-dy) : DIFF_BITS'(dy);
   end

   // shared multiplier
   always_comb begin
      mul_lhs = cmd.sq_b || cmd.mul_y ? b_ff : a_ff;
      if (cmd.mul_x || cmd.mul_y) begin
         mul_rhs = NORM_BITS'(speed_ff);
      end else begin
         mul_rhs = mul_lhs;
      end
      mul_out = PROD_BITS'(mul_lhs) * PROD_BITS'(mul_rhs);
   end

   // one root digit per cycle
   always_comb begin
      root_try = {rem_ff, rad_ff[RAD_BITS-1 -: 2]};
      root_sub = (REM_BITS+2)'({root_ff, 2'b01});
      root_bit = (root_try >= root_sub);
   end

   // one quotient bit per cycle
   always_comb begin
      num     = NUM_BITS'(prod_ff) << FRAC_BITS;
      den     = DEN_BITS'({root_ff, {SPEED_FRAC{1'b0}}});
      div_try = {drem_ff, dlow_ff[QUOT_BITS-1]};
      div_bit = (div_try >= {1'b0, den});
   end

   // move with saturation
   always_comb begin
      sum_x  = {point_x_ff[COORD_BITS-1], point_x_ff} + {disp_x_ff[COORD_BITS-1], disp_x_ff};
      sum_y  = {point_y_ff[COORD_BITS-1], point_y_ff} + {disp_y_ff[COORD_BITS-1], disp_y_ff};
      clip_x = (sum_x[DIFF_BITS-1] != sum_x[DIFF_BITS-2]);
      clip_y = (sum_y[DIFF_BITS-1] != sum_y[DIFF_BITS-2]);
      mv_x   = clip_x ? (sum_x[DIFF_BITS-1] ? COORD_MIN : COORD_MAX) : COORD_BITS'(sum_x);
      mv_y   = clip_y ? (sum_y[DIFF_BITS-1] ? COORD_MIN : COORD_MAX) : COORD_BITS'(sum_y);
   end

   always_comb begin
      nxt_pt_x = point_x_ff;
      nxt_pt_y = point_y_ff;
      nxt_clip = 1'b0;
      case (op_type_ff)
         REQ_MOVE: begin
            nxt_pt_x = mv_x;
            nxt_pt_y = mv_y;
            nxt_clip = clip_x || clip_y;
         end
         REQ_PLACE: begin
            nxt_pt_x = op_x_ff;
            nxt_pt_y = op_y_ff;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      comp_x = make_comp(quot_x_ff, neg_x_ff);
      comp_y = make_comp(quot_ff, neg_y_ff);
      if (stat.zero_dist) begin
         comp_x = '0;
         comp_y = '0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff     <= SPEED_RESET;
         point_x_ff   <= '0;
         point_y_ff   <= '0;
         disp_x_ff    <= '0;
         disp_y_ff    <= '0;
         zero_aim_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            speed_ff <= csr_wr_data;
         end
         if (cmd.commit_simple) begin
            point_x_ff <= nxt_pt_x;
            point_y_ff <= nxt_pt_y;
         end
         if (cmd.commit_aim) begin
            disp_x_ff   <= comp_x;
            disp_y_ff   <= comp_y;
            zero_aim_ff <= stat.zero_dist;
         end
         if (cmd.commit_simple || cmd.commit_aim) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_type_ff <= req_type;
         op_x_ff    <= req_in_x;
         op_y_ff    <= req_in_y;
      end
      if (cmd.diff) begin
         neg_x_ff <= dx[DIFF_BITS-1];
         neg_y_ff <= dy[DIFF_BITS-1];
         a_ff     <= NORM_BITS'(mag_x);
         b_ff     <= NORM_BITS'(mag_y);
      end else if (cmd.norm_shift) begin
         a_ff <= {a_ff[NORM_BITS-2:0], 1'b0};
         b_ff <= {b_ff[NORM_BITS-2:0], 1'b0};
      end
      if (cmd.sq_a || cmd.sq_b || cmd.mul_x || cmd.mul_y) begin
         prod_ff <= mul_out;
      end
      if (cmd.sq_b) begin
         sq_ff <= SQ_BITS'(prod_ff);
      end
      if (cmd.root_init) begin
         rad_ff  <= RAD_BITS'(sq_ff + SQ_BITS'(prod_ff));
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (cmd.root_step) begin
         rad_ff  <= {rad_ff[RAD_BITS-3:0], 2'b00};
         rem_ff  <= root_bit ? REM_BITS'(root_try - root_sub) : REM_BITS'(root_try);
         root_ff <= {root_ff[ROOT_BITS-2:0], root_bit};
      end
      if (cmd.div_init) begin
         drem_ff <= DEN_BITS'(num >> QUOT_BITS);
         dlow_ff <= num[QUOT_BITS-1:0];
         quot_ff <= '0;
      end else if (cmd.div_step) begin
         drem_ff <= div_bit ? DEN_BITS'(div_try - {1'b0, den}) : DEN_BITS'(div_try);
         dlow_ff <= {dlow_ff[QUOT_BITS-2:0], 1'b0};
         quot_ff <= {quot_ff[QUOT_BITS-2:0], div_bit};
      end
      if (cmd.keep_x) begin
         quot_x_ff <= quot_ff;
      end
      if (cmd.commit_simple) begin
         out_pos_x_ff  <= nxt_pt_x;
         out_pos_y_ff  <= nxt_pt_y;
         out_step_x_ff <= disp_x_ff;
         out_step_y_ff <= disp_y_ff;
         out_degen_ff  <= zero_aim_ff;
         out_clip_ff   <= nxt_clip;
      end else if (cmd.commit_aim) begin
         out_pos_x_ff  <= point_x_ff;
         out_pos_y_ff  <= point_y_ff;
         out_step_x_ff <= comp_x;
         out_step_y_ff <= comp_y;
         out_degen_ff  <= stat.zero_dist;
         out_clip_ff   <= 1'b0;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pos_x      = out_pos_x_ff;
   assign rsp_pos_y      = out_pos_y_ff;
   assign rsp_step_x     = out_step_x_ff;
   assign rsp_step_y     = out_step_y_ff;
   assign rsp_degenerate = out_degen_ff;
   assign rsp_clipped    = out_clip_ff;

endmodule

@@ design/aimed_point_motion_stepper.sv @@
// Point stepper: keeps a 2D point and a per-tick step, both signed Q16.8.
// Request channel (req_valid/req_ready): req_type 0 moves the point by the
// step with saturation, 1 places the point at req_in_x/req_in_y, 2 aims the
// step at req_in_x/req_in_y with length set by the speed register, 3 only
// reports. Every request returns one response on rsp_valid/rsp_ready with
// the point, the step, the degenerate flag and the clipped flag.
// csr_wr_en/csr_wr_data write the speed register (unsigned Q8.8), idle only.
// Requests are handled one at a time. Move, place and report commit their
// response from the exec state once the output register is free and then
// return to idle. Aim runs a shift-by-one normalizer (6 to 29 shifts), two
// squarings on a shared 30x30 multiplier, a bit-serial square root giving a
// 31-bit root and two bit-serial divisions giving 17-bit quotients; an aim
// at the point itself goes from the normalizer straight to the done state.
// Reset (synchronous, active high) clears point, step and flags and loads a
// speed of 1.0 pixel. A stalled response holds in the output register;
// the block takes the next request but holds its result until the output
// register frees up.
module aimed_point_motion_stepper (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [1:0]                             req_type,
   input  logic signed [apms_pkg::COORD_BITS-1:0] req_in_x,
   input  logic signed [apms_pkg::COORD_BITS-1:0] req_in_y,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [apms_pkg::COORD_BITS-1:0] rsp_pos_x,
   output logic signed [apms_pkg::COORD_BITS-1:0] rsp_pos_y,
   output logic signed [apms_pkg::COORD_BITS-1:0] rsp_step_x,
   output logic signed [apms_pkg::COORD_BITS-1:0] rsp_step_y,
   output logic                                   rsp_degenerate,
   output logic                                   rsp_clipped,
   input  logic                                   csr_wr_en,
   input  logic [apms_pkg::SPEED_BITS-1:0]        csr_wr_data
);
   import apms_pkg::*;

   `include "aimed_point_motion_stepper_macros.svh"

   dp_cmd_type  cmd;
   dp_stat_type stat;

   apms_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   apms_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_type       (req_type),
      .req_in_x       (req_in_x),
      .req_in_y       (req_in_y),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_pos_x      (rsp_pos_x),
      .rsp_pos_y      (rsp_pos_y),
      .rsp_step_x     (rsp_step_x),
      .rsp_step_y     (rsp_step_y),
      .rsp_degenerate (rsp_degenerate),
      .rsp_clipped    (rsp_clipped)
   );

   `APMS_ASSERT_NEXT(a_busy_after_request, clock, reset, req_valid && req_ready, !req_ready)
   `APMS_ASSERT_NOW(a_degenerate_zero_step, clock, reset, rsp_valid && rsp_degenerate, rsp_step_x == '0 && rsp_step_y == '0)
   `APMS_ASSERT_NOW(a_clipped_at_limit, clock, reset, rsp_valid && rsp_clipped, rsp_pos_x == COORD_MAX || rsp_pos_x == COORD_MIN || rsp_pos_y == COORD_MAX || rsp_pos_y == COORD_MIN)

endmodule
